// ===== rtl/ptw_pkg.sv =====
package ptw_pkg;

  // Input item fields
  typedef struct packed {
    logic        action;
    logic [31:0] lin_addr;
    logic [3:0]  access_mode;
    logic [31:0] read_data;
  } ptw_in_t;

  // Result item fields
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] mem_addr;
    logic [31:0] write_data;
    logic [31:0] phys_addr;
    logic        page_global;
    logic        page_nx;
    logic [4:0]  pf_code;
    logic [31:0] fault_addr;
    logic        last;
  } ptw_out_t;

  // Configuration snapshot used by the front end
  typedef struct packed {
    logic        paging_enable;
    logic        write_protect;
    logic        pae_enable;
    logic        pse_enable;
    logic        nx_enable;
    logic [31:0] dir_base;
  } ptw_cfg_t;

  // Result bundle handed from front to back: up to three results
  typedef struct packed {
    logic [1:0] cnt;
    ptw_out_t   r0;
    ptw_out_t   r1;
    ptw_out_t   r2;
  } ptw_bundle_t;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_PAGE  = 3'd2;
  localparam logic [2:0] KIND_PF    = 3'd3;
  localparam logic [2:0] KIND_GP    = 3'd4;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PDE     = 3'd1;
  localparam logic [2:0] PH_PTE     = 3'd2;
  localparam logic [2:0] PH_PDPT_LO = 3'd3;
  localparam logic [2:0] PH_PDPT_HI = 3'd4;
  localparam logic [2:0] PH_PDE_LO  = 3'd5;
  localparam logic [2:0] PH_PDE_HI  = 3'd6;
  localparam logic [2:0] PH_PAE_PTE = 3'd7;

  localparam logic [2:0] REG_PAGING = 3'd0;
  localparam logic [2:0] REG_WP     = 3'd1;
  localparam logic [2:0] REG_PAE    = 3'd2;
  localparam logic [2:0] REG_PSE    = 3'd3;
  localparam logic [2:0] REG_NX     = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;

endpackage

// ===== rtl/ptw_front.sv =====
module ptw_front import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ptw_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  ptw_in_t     in_data,
  output logic        push,
  output ptw_bundle_t push_data,
  input  logic        q_full
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] lin_r, lin_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [31:0] dent_r, dent_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [31:0] upper_r, upper_nxt;
  logic        nx_r, nx_nxt;

  logic        take;
  ptw_bundle_t b;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  function automatic ptw_out_t mk(input logic [2:0] k, input logic [31:0] ma,
                                  input logic [31:0] wd, input logic [31:0] pa,
                                  input logic g, input logic nx,
                                  input logic [4:0] ec, input logic [31:0] fa,
                                  input logic lst);
    ptw_out_t o;
    o.kind = k; o.mem_addr = ma; o.write_data = wd; o.phys_addr = pa;
    o.page_global = g; o.page_nx = nx; o.pf_code = ec; o.fault_addr = fa;
    o.last = lst;
    return o;
  endfunction

  // Walk step: classify the item and build its results
  always_comb begin
    logic [31:0] d, lin, nw, pde, mask, a, pteaddr;
    logic        wr, us, den;
    logic [4:0]  e2, e3;
    logic [2:0]  n;
    ptw_out_t    res [3];
    d = in_data.read_data;
    lin = lin_r;
    wr = mode_r[1];
    us = mode_r[2];
    e2 = {2'b00, us, wr, 1'b0};
    e3 = e2 | {(mode_r[3] && cfg.nx_enable), 4'b0000};
    nw = '0; pde = dent_r; mask = '0; a = '0; pteaddr = '0; den = 1'b0;
    n = '0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    phase_nxt = phase_r; lin_nxt = lin_r; mode_nxt = mode_r; dent_nxt = dent_r;
    daddr_nxt = daddr_r; upper_nxt = upper_r; nx_nxt = nx_r;

    if (!in_data.action) begin
      lin_nxt = in_data.lin_addr;
      mode_nxt = in_data.access_mode;
      if (!cfg.paging_enable) begin
        res[0] = mk(KIND_PAGE, '0, '0, {in_data.lin_addr[31:12], 12'h000}, 1'b0,
                    1'b0, '0, '0, 1'b1);
        n = 3'd1; phase_nxt = PH_IDLE;
      end else if (!cfg.pae_enable) begin
        a = cfg.dir_base + {20'd0, in_data.lin_addr[31:22], 2'b00};
        daddr_nxt = a; phase_nxt = PH_PDE;
        res[0] = mk(KIND_READ, a, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
        n = 3'd1;
      end else begin
        a = {cfg.dir_base[31:5], in_data.lin_addr[31:30], 3'b000};
        daddr_nxt = a; phase_nxt = PH_PDPT_LO;
        res[0] = mk(KIND_READ, a, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
        n = 3'd1;
      end
    end else begin
      case (phase_r)
        PH_PDE: begin
          den = (wr && !d[1] && (us || cfg.write_protect)) || (us && !d[2]);
          nw = d | 32'h20 | {25'd0, wr, 6'd0};
          if (!d[0]) begin
            res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0, e2, lin, 1'b1);
            n = 3'd1; phase_nxt = PH_IDLE;
          end else if (d[7] && cfg.pse_enable) begin
            phase_nxt = PH_IDLE;
            if (den) begin
              res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0, e2 | 5'd1, lin, 1'b1);
              n = 3'd1;
            end else begin
              if (nw != d) begin
                res[n[1:0]] = mk(KIND_WRITE, daddr_r, nw, '0, 1'b0, 1'b0, '0, '0, 1'b0);
                n = n + 3'd1;
              end
              res[n[1:0]] = mk(KIND_PAGE, '0, '0, {d[31:22], lin[21:12], 12'h000},
                               d[8], 1'b0, '0, '0, 1'b1);
              n = n + 3'd1;
            end
          end else begin
            dent_nxt = d; phase_nxt = PH_PTE;
            res[0] = mk(KIND_READ, {d[31:12], lin[21:12], 2'b00}, '0, '0, 1'b0, 1'b0,
                        '0, '0, 1'b1);
            n = 3'd1;
          end
        end
        PH_PTE, PH_PAE_PTE: begin
          if (phase_r == PH_PTE) begin
            den = (wr && !(d[1] && pde[1]) && (us || cfg.write_protect)) ||
                  (us && !(d[2] && pde[2]));
            pteaddr = {pde[31:12], lin[21:12], 2'b00};
          end else begin
            den = (wr && !d[1] && (us || cfg.write_protect)) || (us && !d[2]);
            pteaddr = {pde[31:12], lin[20:12], 3'b000};
          end
          nw = d | 32'h20 | {25'd0, wr, 6'd0};
          phase_nxt = PH_IDLE;
          if (!d[0]) begin
            res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0,
                        (phase_r == PH_PTE) ? e2 : e3, lin, 1'b1);
            n = 3'd1;
          end else if (den) begin
            res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0,
                        ((phase_r == PH_PTE) ? e2 : e3) | 5'd1, lin, 1'b1);
            n = 3'd1;
          end else begin
            if (!pde[5]) begin
              res[n[1:0]] = mk(KIND_WRITE, daddr_r, pde | 32'h20, '0, 1'b0, 1'b0, '0,
                               '0, 1'b0);
              n = n + 3'd1;
            end
            if (nw != d) begin
              res[n[1:0]] = mk(KIND_WRITE, pteaddr, nw, '0, 1'b0, 1'b0, '0, '0, 1'b0);
              n = n + 3'd1;
            end
            res[n[1:0]] = mk(KIND_PAGE, '0, '0, {d[31:12], 12'h000}, d[8],
                             (phase_r == PH_PAE_PTE) && nx_r, '0, '0, 1'b1);
            n = n + 3'd1;
          end
        end
        PH_PDPT_LO: begin
          if (!d[0]) begin
            res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0, e2, lin, 1'b1);
            phase_nxt = PH_IDLE;
          end else begin
            upper_nxt = d; phase_nxt = PH_PDPT_HI;
            res[0] = mk(KIND_READ, daddr_r + 32'd4, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
          end
          n = 3'd1;
        end
        PH_PDPT_HI: begin
          if (d[31:4] != '0) begin
            res[0] = mk(KIND_GP, '0, '0, '0, 1'b0, 1'b0, '0, lin, 1'b1);
            phase_nxt = PH_IDLE;
          end else begin
            a = {upper_r[31:12], lin[29:21], 3'b000};
            daddr_nxt = a; phase_nxt = PH_PDE_LO;
            res[0] = mk(KIND_READ, a, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
          end
          n = 3'd1;
        end
        PH_PDE_LO: begin
          dent_nxt = d; phase_nxt = PH_PDE_HI;
          res[0] = mk(KIND_READ, daddr_r + 32'd4, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
          n = 3'd1;
        end
        PH_PDE_HI: begin
          mask = cfg.nx_enable ? 32'h7FFF_FFF0 : 32'hFFFF_FFF0;
          den = (wr && !pde[1] && (us || cfg.write_protect)) || (us && !pde[2]);
          nw = pde | 32'h20 | {25'd0, wr, 6'd0};
          phase_nxt = PH_IDLE;
          if ((d & mask) != '0) begin
            res[0] = mk(KIND_GP, '0, '0, '0, 1'b0, 1'b0, '0, lin, 1'b1);
            n = 3'd1;
          end else begin
            nx_nxt = d[31] && cfg.nx_enable;
            if (!pde[0]) begin
              res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0, e3, lin, 1'b1);
              n = 3'd1;
            end else if (den) begin
              res[0] = mk(KIND_PF, '0, '0, '0, 1'b0, 1'b0, e3 | 5'd1, lin, 1'b1);
              n = 3'd1;
            end else if (pde[7]) begin
              if (nw != pde) begin
                res[n[1:0]] = mk(KIND_WRITE, daddr_r, nw, '0, 1'b0, 1'b0, '0, '0, 1'b0);
                n = n + 3'd1;
              end
              res[n[1:0]] = mk(KIND_PAGE, '0, '0, {pde[31:21], lin[20:12], 12'h000},
                               pde[8], d[31] && cfg.nx_enable, '0, '0, 1'b1);
              n = n + 3'd1;
            end else begin
              phase_nxt = PH_PAE_PTE;
              res[0] = mk(KIND_READ, {pde[31:12], lin[20:12], 3'b000}, '0, '0, 1'b0,
                          1'b0, '0, '0, 1'b1);
              n = 3'd1;
            end
          end
        end
        default: begin
          n = '0;
        end
      endcase
    end
    b.cnt = n[1:0];
    b.r0 = res[0];
    b.r1 = res[1];
    b.r2 = res[2];
  end

  assign push      = take && (b.cnt != 2'd0);
  assign push_data = b;

  // Walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      lin_r <= '0; mode_r <= '0; dent_r <= '0; daddr_r <= '0; upper_r <= '0;
      nx_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      lin_r <= lin_nxt; mode_r <= mode_nxt; dent_r <= dent_nxt;
      daddr_r <= daddr_nxt; upper_r <= upper_nxt; nx_r <= nx_nxt;
    end
  end

endmodule

// ===== rtl/ptw_queue.sv =====
module ptw_queue import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ptw_bundle_t push_data,
  output logic        full,
  output logic        empty,
  output ptw_bundle_t head,
  input  logic        pop
);

  // Two-entry queue of result bundles
  ptw_bundle_t mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/ptw_back.sv =====
module ptw_back import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  ptw_bundle_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output ptw_out_t    out_data
);

  // Sequence the results of the head bundle one per transfer
  logic [1:0] idx_r;
  logic       xfer;

  assign out_valid = !q_empty;
  assign xfer      = out_valid && !out_stall;
  assign q_pop     = xfer && (idx_r + 2'd1 == q_head.cnt);

  always_comb begin
    case (idx_r)
      2'd0:    out_data = q_head.r0;
      2'd1:    out_data = q_head.r1;
      default: out_data = q_head.r2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (q_pop) begin
      idx_r <= '0;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

// ===== rtl/x86_page_table_walker.sv =====
// Channel | Direction | Struct     | Handshake
// in_     | input     | ptw_in_t   | in_valid / in_stall
// out_    | output    | ptw_out_t  | out_valid / out_stall
// cfg_    | input     | 3b idx/32b | cfg_wr_en, no wait
// The front end takes one item per cycle while the two-entry bundle queue has room.
// Each item yields zero to three results (a response while idle yields none),
// delivered one per cycle by the back end while out_stall is low.
// An accepted item's results are registered in the bundle queue and shown once their bundle reaches its head.
// Reset (rst_n low, synchronous) clears walk state, registers and the queue.
// Output stalls back up into in_stall only once the queue is full.
module x86_page_table_walker import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  ptw_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ptw_out_t    out_data
);

  ptw_cfg_t    cfg_r;
  logic        push, q_full, q_empty, q_pop;
  ptw_bundle_t push_data, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAGING: cfg_r.paging_enable <= cfg_data[0];
        REG_WP:     cfg_r.write_protect <= cfg_data[0];
        REG_PAE:    cfg_r.pae_enable    <= cfg_data[0];
        REG_PSE:    cfg_r.pse_enable    <= cfg_data[0];
        REG_NX:     cfg_r.nx_enable     <= cfg_data[0];
        REG_BASE:   cfg_r.dir_base      <= cfg_data;
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  ptw_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .push(push), .push_data(push_data), .q_full(q_full)
  );

  ptw_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .empty(q_empty), .head(q_head), .pop(q_pop)
  );

  ptw_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ===== rtl/ptw_checker.sv =====
module ptw_checker import ptw_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ptw_out_t out_data
);

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Kind code is always a defined one
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= KIND_GP)
    else $error("bad result kind");

  // Writes are never the final result
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WRITE |-> !out_data.last)
    else $error("write-back marked last");

  // Nothing is shown and the input is open right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall after reset");

endmodule

bind x86_page_table_walker ptw_checker u_ptw_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ptw_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  ptw_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  ptw_out_t    out_data;

  x86_page_table_walker u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Walker model state
  logic        m_paging, m_wp, m_pae, m_pse, m_nx;
  logic [31:0] m_base;
  logic [2:0]  m_phase;
  logic [31:0] m_lin, m_pde, m_pde_addr, m_upper;
  logic [3:0]  m_mode;
  logic        m_noexec;

  ptw_out_t walk_results[$];
  int       mismatches;
  int       n_items, n_results, n_pages, n_pf, n_gp, n_wb;
  bit       hold_off;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic ptw_out_t mk(logic [2:0] k);
    ptw_out_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic push_read(logic [31:0] a);
    ptw_out_t r;
    r = mk(KIND_READ);
    r.mem_addr = a;
    walk_results.push_back(r);
  endtask

  task automatic push_write(logic [31:0] a, logic [31:0] d);
    ptw_out_t r;
    r = mk(KIND_WRITE);
    r.last = 1'b0;
    r.mem_addr = a;
    r.write_data = d;
    walk_results.push_back(r);
  endtask

  task automatic push_page(logic [31:0] p, logic g, logic nx);
    ptw_out_t r;
    r = mk(KIND_PAGE);
    r.phys_addr = {p[31:12], 12'h000};
    r.page_global = g;
    r.page_nx = nx;
    walk_results.push_back(r);
    m_phase = PH_IDLE;
  endtask

  task automatic push_pf(logic [4:0] e);
    ptw_out_t r;
    r = mk(KIND_PF);
    r.pf_code = e;
    r.fault_addr = m_lin;
    walk_results.push_back(r);
    m_phase = PH_IDLE;
  endtask

  task automatic push_gp();
    ptw_out_t r;
    r = mk(KIND_GP);
    r.fault_addr = m_lin;
    walk_results.push_back(r);
    m_phase = PH_IDLE;
  endtask

  function automatic logic [4:0] fault_bits(bit pae);
    logic [4:0] e;
    e = {2'b00, m_mode[2], m_mode[1], 1'b0};
    if (pae && m_mode[3] && m_nx) e[4] = 1'b1;
    return e;
  endfunction

  function automatic bit access_denied(logic [31:0] ent);
    if (m_mode[1] && !ent[1] && (m_mode[2] || m_wp)) return 1;
    if (m_mode[2] && !ent[2]) return 1;
    return 0;
  endfunction

  // Advance the walk for one accepted transfer, queueing expected results
  task automatic predict_walk(ptw_in_t it);
    logic [31:0] d, lin, nw, a, msk;
    d = it.read_data;
    if (!it.action) begin
      m_lin = it.lin_addr;
      m_mode = it.access_mode;
      lin = m_lin;
      if (!m_paging) push_page(lin, 0, 0);
      else if (!m_pae) begin
        a = m_base + ((lin >> 20) & 32'hFFC);
        m_pde_addr = a;
        m_phase = PH_PDE;
        push_read(a);
      end else begin
        a = (m_base & ~32'd31) | ((lin >> 27) & 32'h18);
        m_pde_addr = a;
        m_phase = PH_PDPT_LO;
        push_read(a);
      end
      return;
    end
    lin = m_lin;
    case (m_phase)
      PH_PDE: begin
        if (!d[0]) push_pf(fault_bits(0));
        else if (d[7] && m_pse) begin
          if (access_denied(d)) push_pf(fault_bits(0) | 5'd1);
          else begin
            nw = d | 32'h20 | (32'(m_mode[1]) << 6);
            if (nw != d) push_write(m_pde_addr, nw);
            push_page((d & 32'hFFC00000) | (lin & 32'h3FF000), d[8], 0);
          end
        end else begin
          m_pde = d;
          m_phase = PH_PTE;
          push_read((d & 32'hFFFFF000) | ((lin >> 10) & 32'hFFC));
        end
      end
      PH_PTE: begin
        if (!d[0]) push_pf(fault_bits(0));
        else if (access_denied(d & m_pde)) push_pf(fault_bits(0) | 5'd1);
        else begin
          if (!m_pde[5]) push_write(m_pde_addr, m_pde | 32'h20);
          nw = d | 32'h20 | (32'(m_mode[1]) << 6);
          if (nw != d)
            push_write((m_pde & 32'hFFFFF000) | ((lin >> 10) & 32'hFFC), nw);
          push_page(d, d[8], 0);
        end
      end
      PH_PDPT_LO: begin
        if (!d[0]) push_pf(fault_bits(0));
        else begin
          m_upper = d;
          m_phase = PH_PDPT_HI;
          push_read(m_pde_addr + 32'd4);
        end
      end
      PH_PDPT_HI: begin
        if (d & ~32'd15) push_gp();
        else begin
          a = (m_upper & 32'hFFFFF000) | ((lin >> 18) & 32'hFF8);
          m_pde_addr = a;
          m_phase = PH_PDE_LO;
          push_read(a);
        end
      end
      PH_PDE_LO: begin
        m_pde = d;
        m_phase = PH_PDE_HI;
        push_read(m_pde_addr + 32'd4);
      end
      PH_PDE_HI: begin
        msk = m_nx ? 32'h7FFFFFF0 : 32'hFFFFFFF0;
        if (d & msk) push_gp();
        else begin
          m_noexec = d[31] & m_nx;
          if (!m_pde[0]) push_pf(fault_bits(1));
          else if (access_denied(m_pde)) push_pf(fault_bits(1) | 5'd1);
          else if (m_pde[7]) begin
            nw = m_pde | 32'h20 | (32'(m_mode[1]) << 6);
            if (nw != m_pde) push_write(m_pde_addr, nw);
            push_page((m_pde & 32'hFFE00000) | (lin & 32'h1FF000), m_pde[8], m_noexec);
          end else begin
            m_phase = PH_PAE_PTE;
            push_read((m_pde & 32'hFFFFF000) | ((lin >> 9) & 32'hFF8));
          end
        end
      end
      PH_PAE_PTE: begin
        if (!d[0]) push_pf(fault_bits(1));
        else if (access_denied(d)) push_pf(fault_bits(1) | 5'd1);
        else begin
          if (!m_pde[5]) push_write(m_pde_addr, m_pde | 32'h20);
          nw = d | 32'h20 | (32'(m_mode[1]) << 6);
          if (nw != d)
            push_write((m_pde & 32'hFFFFF000) | ((lin >> 9) & 32'hFF8), nw);
          push_page(d, d[8], m_noexec);
        end
      end
      default: ;
    endcase
  endtask

  // Compare each accepted result transfer with the oldest expectation
  always @(posedge clk) begin
    ptw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (walk_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = walk_results.pop_front();
        case (want.kind)
          KIND_PAGE: n_pages++;
          KIND_PF:   n_pf++;
          KIND_GP:   n_gp++;
          KIND_WRITE: n_wb++;
          default: ;
        endcase
        if (out_data.kind != want.kind || out_data.mem_addr != want.mem_addr ||
            out_data.write_data != want.write_data ||
            out_data.phys_addr != want.phys_addr ||
            out_data.page_global != want.page_global ||
            out_data.page_nx != want.page_nx ||
            out_data.pf_code != want.pf_code ||
            out_data.fault_addr != want.fault_addr || out_data.last != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  // Receiver: random stall per transfer, plus one long hold-off
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PAGING: m_paging = v[0];
      REG_WP:     m_wp = v[0];
      REG_PAE:    m_pae = v[0];
      REG_PSE:    m_pse = v[0];
      REG_NX:     m_nx = v[0];
      REG_BASE:   m_base = v;
      default: ;
    endcase
  endtask

  // Send one item with a random gap before it; keeps valid high back to back.
  // The prediction runs at the accepting edge, in this thread.
  task automatic send_item(ptw_in_t it, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 10) : 0;
    if (gaps && $urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_walk(it);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (walk_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic ptw_in_t req(logic [31:0] a, logic [3:0] m);
    ptw_in_t it;
    it = '0;
    it.lin_addr = a;
    it.access_mode = m;
    it.read_data = $urandom();
    return it;
  endfunction

  function automatic ptw_in_t rsp(logic [31:0] d);
    ptw_in_t it;
    it = '0;
    it.action = 1'b1;
    it.lin_addr = $urandom();
    it.access_mode = $urandom();
    it.read_data = d;
    return it;
  endfunction

  // Random entry: mostly present and permissive, sometimes anything
  function automatic logic [31:0] rand_entry();
    logic [31:0] e;
    e = $urandom();
    if ($urandom_range(0, 4) != 0) e[0] = 1'b1;
    if ($urandom_range(0, 2) != 0) e[2:1] = 2'b11;
    return e;
  endfunction

  function automatic logic [31:0] rand_high();
    logic [31:0] h;
    h = $urandom_range(0, 15);
    if ($urandom_range(0, 1)) h[31] = 1'b1;
    if ($urandom_range(0, 9) == 0) h = $urandom();
    return h;
  endfunction

  // Directed table: mode bits, then request or response
  typedef struct {
    logic [4:0] cfgv;   // paging, wp, pae, pse, nx
    logic       act;
    logic [31:0] val;   // lin_addr for requests, read_data for responses
    logic [3:0] mode;
    bit         chk;    // typed-in expectation present
    logic [2:0] ek;
    logic [31:0] ephys;
    logic [4:0] eerr;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // paging off: pass-through at the address extremes
    '{5'b00000, 0, 32'hFFFF_FFFF, 4'hF, 1, KIND_PAGE, 32'hFFFF_F000, 0},
    '{5'b00000, 0, 32'h0000_0000, 4'h0, 1, KIND_PAGE, 32'h0, 0},
    // response while idle is ignored
    '{5'b00000, 1, 32'hFFFF_FFFF, 4'h0, 0, 0, 0, 0},
    // two-level: PDE not present, user write
    '{5'b10000, 0, 32'h1234_5678, 4'h6, 0, 0, 0, 0},
    '{5'b10000, 1, 32'h0000_0000, 4'h0, 1, KIND_PF, 0, 5'h06},
    // two-level full walk with write-backs
    '{5'b10000, 0, 32'hFFFF_FFFF, 4'h2, 0, 0, 0, 0},
    '{5'b10000, 1, 32'h0000_1007, 4'h0, 0, 0, 0, 0},
    '{5'b10000, 1, 32'hABCD_E107, 4'h0, 0, 0, 0, 0},
    // user write to read-only PTE: protection fault
    '{5'b10000, 0, 32'h0040_0000, 4'h6, 0, 0, 0, 0},
    '{5'b10000, 1, 32'h0000_2027, 4'h0, 0, 0, 0, 0},
    '{5'b10000, 1, 32'h0000_3005, 4'h0, 1, KIND_PF, 0, 5'h07},
    // 4 MB page, supervisor write with write protect on a read-only PDE
    '{5'b11010, 0, 32'h8040_1000, 4'h2, 0, 0, 0, 0},
    '{5'b11010, 1, 32'hFFC0_01E7 & 32'hFFFF_FF85, 4'h0, 1, KIND_PF, 0, 5'h03},
    '{5'b11010, 0, 32'h8040_1000, 4'h0, 0, 0, 0, 0},
    '{5'b11010, 1, 32'hFFC0_01E7, 4'h0, 0, 0, 0, 0},
    // walk left open; the next request abandons it
    '{5'b10000, 0, 32'h0000_5000, 4'h0, 0, 0, 0, 0},
    // PAE: PDPTE reserved high bits -> GP
    '{5'b10101, 0, 32'hC000_0000, 4'hA, 0, 0, 0, 0},
    '{5'b10101, 1, 32'h0000_1001, 4'h0, 0, 0, 0, 0},
    '{5'b10101, 1, 32'h0000_0010, 4'h0, 1, KIND_GP, 0, 0},
    // PAE 2 MB page with NX, fetch
    '{5'b10101, 0, 32'h7FFF_FFFF, 4'h8, 0, 0, 0, 0},
    '{5'b10101, 1, 32'h0000_1001, 4'h0, 0, 0, 0, 0},
    '{5'b10101, 1, 32'h0000_000F, 4'h0, 0, 0, 0, 0},
    '{5'b10101, 1, 32'hFFE0_01A7, 4'h0, 0, 0, 0, 0},
    '{5'b10101, 1, 32'h8000_0000, 4'h0, 0, 0, 0, 0},
    // PAE PDPTE not present, user fetch with NX on
    '{5'b10101, 0, 32'h0000_0000, 4'hC, 0, 0, 0, 0}
  };

  initial begin
    ptw_in_t it;
    ptw_out_t w;
    logic [31:0] lin;
    logic [3:0] md;
    int nsteps, len, ph;
    bit hard;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 0;
    {m_paging, m_wp, m_pae, m_pse, m_nx} = '0;
    m_base = '0;
    m_phase = PH_IDLE;
    {m_lin, m_pde, m_pde_addr, m_upper} = '0;
    m_mode = '0;
    m_noexec = 0;
    mismatches = 0;
    {n_items, n_results, n_pages, n_pf, n_gp, n_wb} = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    cfg_write(REG_BASE, 32'hFFFF_FFFF);
    cfg_write(REG_BASE, 32'h0000_0000);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfgv != {m_paging, m_wp, m_pae, m_pse, m_nx}) begin
        drain();
        cfg_write(REG_PAGING, 32'(dir_rows[i].cfgv[4]));
        cfg_write(REG_WP, 32'(dir_rows[i].cfgv[3]));
        cfg_write(REG_PAE, 32'(dir_rows[i].cfgv[2]));
        cfg_write(REG_PSE, 32'(dir_rows[i].cfgv[1]));
        cfg_write(REG_NX, 32'(dir_rows[i].cfgv[0]));
      end
      it = dir_rows[i].act ? rsp(dir_rows[i].val) : req(dir_rows[i].val, dir_rows[i].mode);
      send_item(it, 0);
      if (dir_rows[i].chk) begin
        w = walk_results[walk_results.size() - 1];
        if (w.kind != dir_rows[i].ek || w.phys_addr != dir_rows[i].ephys ||
            w.pf_code != dir_rows[i].eerr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: typed expectation %0d/%h/%h, predicted %h",
                     i, dir_rows[i].ek, dir_rows[i].ephys, dir_rows[i].eerr, w);
        end
      end
    end
    send_item(rsp(32'h0000_0000), 0);
    drain();

    // Random phases, each with its own register setting
    for (int p = 0; p < 12; p++) begin
      cfg_write(REG_PAGING, 32'((p % 6) != 5));
      cfg_write(REG_WP, $urandom_range(0, 1));
      cfg_write(REG_PAE, 32'(p[0]));
      cfg_write(REG_PSE, $urandom_range(0, 1));
      cfg_write(REG_NX, $urandom_range(0, 1));
      cfg_write(REG_BASE, (p == 3) ? 32'hFFFF_FFFF : $urandom());
      if (p == 4) hold_off = 1;
      nsteps = 0;
      while (nsteps < 32) begin
        lin = $urandom();
        md = $urandom();
        send_item(req(lin, md), p != 4);
        nsteps++;
        hard = $urandom_range(0, 7) == 0;
        len = m_pae ? 5 : 2;
        for (ph = 0; ph < len && m_phase != PH_IDLE; ph++) begin
          if (hard && $urandom_range(0, 2) == 0) break;
          if (m_phase == PH_PDPT_HI || m_phase == PH_PDE_HI)
            it = rsp(rand_high());
          else
            it = rsp(hard ? $urandom() : rand_entry());
          send_item(it, p != 4);
          nsteps++;
        end
        if (hard && $urandom_range(0, 1)) begin
          send_item(rsp($urandom()), 1);
          nsteps++;
        end
      end
      drain();
    end

    in_valid <= 1'b0;
    while (walk_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d transfers in, %0d results: %0d pages, %0d page faults,",
             n_items, n_results, n_pages, n_pf);
    $display("  %0d protection faults, %0d write-backs, two-level and PAE walks",
             n_gp, n_wb);
    if (mismatches == 0 && walk_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d, outstanding: %0d", mismatches, walk_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
